FILE: rtl/idebl_pkg.sv
// Shared types and constants for the input debounce / event / blink block.
// No dependencies.
package idebl_pkg;

  localparam int INPUT_CHANNELS  = 20;
  localparam int OUTPUT_CHANNELS = 17;
  localparam int COUNT_BITS      = 8;
  localparam int THRESH_BITS     = 8;
  localparam int SLOW_BITS       = 3;
  localparam int CH_BITS         = 5;
  localparam int CMD_BITS        = 3;
  localparam int MODE_BITS       = 2;
  localparam int CFG_IDX_BITS    = 2;
  localparam int CFG_DATA_BITS   = THRESH_BITS;
  localparam int CMP_BITS        = (COUNT_BITS > THRESH_BITS) ? COUNT_BITS : THRESH_BITS;

  localparam logic [THRESH_BITS-1:0] THRESH_RESET    = THRESH_BITS'(5);
  localparam logic [SLOW_BITS-1:0]   SLOW_TICKS_RESET = SLOW_BITS'(5);

  typedef enum logic [CMD_BITS-1:0] {
    CMD_SCAN      = 3'd0,
    CMD_TICK      = 3'd1,
    CMD_READ_RISE = 3'd2,
    CMD_READ_FALL = 3'd3,
    CMD_SET_MODE  = 3'd4
  } cmd_e;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_OFF  = 2'd0,
    MODE_ON   = 2'd1,
    MODE_SLOW = 2'd2,
    MODE_FAST = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_THRESHOLD  = 2'd0,
    CFG_SLOW_TICKS = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [CMD_BITS-1:0]       command;
    logic [INPUT_CHANNELS-1:0] raw_levels;
    logic [CH_BITS-1:0]        channel_index;
    logic [MODE_BITS-1:0]      output_mode;
  } in_item_t;

  typedef struct packed {
    logic [INPUT_CHANNELS-1:0]  stable_levels;
    logic [OUTPUT_CHANNELS-1:0] pin_levels;
    logic                       event_seen;
  } out_item_t;

endpackage

FILE: rtl/idebl_in_if.sv
// Input item channel: valid/ready handshake carrying one command item.
// Depends on idebl_pkg.
interface idebl_in_if import idebl_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/idebl_out_if.sv
// Result item channel: valid/ready handshake carrying one result item.
// Depends on idebl_pkg.
interface idebl_out_if import idebl_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/idebl_debounce.sv
// Per-channel saturating mismatch counters and the debounced level register.
// Depends on idebl_pkg.
module idebl_debounce import idebl_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      scan_i,
  input  logic [INPUT_CHANNELS-1:0] raw_i,
  input  logic [THRESH_BITS-1:0]    threshold_i,
  output logic [INPUT_CHANNELS-1:0] stable_d_o,
  output logic [INPUT_CHANNELS-1:0] stable_q_o
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [COUNT_BITS-1:0]     cnt_q [INPUT_CHANNELS];
  logic [COUNT_BITS-1:0]     cnt_d [INPUT_CHANNELS];
  logic [COUNT_BITS-1:0]     cnt_inc [INPUT_CHANNELS];
  logic [INPUT_CHANNELS-1:0] stable_q;
  logic [INPUT_CHANNELS-1:0] stable_d;

  always_comb begin
    for (int i = 0; i < INPUT_CHANNELS; i++) begin
      cnt_d[i]    = cnt_q[i];
      stable_d[i] = stable_q[i];
      cnt_inc[i]  = (cnt_q[i] == COUNT_MAX) ? cnt_q[i] : cnt_q[i] + COUNT_BITS'(1);
      if (scan_i) begin
        if (raw_i[i] != stable_q[i]) begin
          cnt_d[i] = cnt_inc[i];
          if (CMP_BITS'(cnt_inc[i]) >= CMP_BITS'(threshold_i)) begin
            stable_d[i] = raw_i[i];
          end
        end else begin
          cnt_d[i] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= '0;
      for (int i = 0; i < INPUT_CHANNELS; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      stable_q <= stable_d;
      for (int i = 0; i < INPUT_CHANNELS; i++) begin
        cnt_q[i] <= cnt_d[i];
      end
    end
  end

  assign stable_d_o = stable_d;
  assign stable_q_o = stable_q;

endmodule

FILE: rtl/input_debounce_event_blink.sv
// Top level: panel input debounce with sticky edge events and blinking pins.
// Depends on idebl_pkg, idebl_in_if, idebl_out_if, idebl_debounce.
//
// Usage:
//   in_i carries command items (scan, tick, read-and-clear rise/fall event,
//   set output mode). Every accepted item yields exactly one result item on
//   out_o: the debounced levels after the item, the pin levels last driven
//   by a scan, and the event flag for read commands.
//   cfg_we_i/cfg_idx_i/cfg_data_i write the debounce threshold (index 0)
//   and the slow blink tick limit (index 1); write only while idle.
// Result: a result is valid in the cycle after its item is accepted.
// Throughput: one item per cycle while out_o is not stalled; all 20 channel
//   counters update in parallel in the cycle of acceptance, so nothing iterates.
// Reset: counters, stable levels, event flags, modes and pins clear; both
//   blink phases start high; threshold and slow limit return to 5.
// Stall: a single result register sits on the output. While it holds an
//   untaken result, in_i.ready follows out_o.ready, so a stalled receiver
//   holds off new items without losing any.
module input_debounce_event_blink import idebl_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  idebl_in_if.sink                 in_i,
  idebl_out_if.source              out_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  logic                       accept;
  logic                       scan_en;
  logic [THRESH_BITS-1:0]     thr_q;
  logic [SLOW_BITS-1:0]       slow_ticks_q;
  logic [INPUT_CHANNELS-1:0]  stable_d, stable_q;
  logic [INPUT_CHANNELS-1:0]  rise_q, rise_d;
  logic [INPUT_CHANNELS-1:0]  fall_q, fall_d;
  mode_e                      mode_q [OUTPUT_CHANNELS];
  mode_e                      mode_d [OUTPUT_CHANNELS];
  logic [OUTPUT_CHANNELS-1:0] pin_q, pin_d, pin_scan;
  logic                       fast_q, fast_d;
  logic                       slow_q, slow_d;
  logic [SLOW_BITS-1:0]       tick_q, tick_d;
  logic [SLOW_BITS:0]         tick_inc;
  logic                       seen;
  logic                       out_valid_q;
  out_item_t                  out_data_q;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign scan_en    = accept && (in_i.data.command == CMD_SCAN);

  idebl_debounce u_debounce (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .scan_i      (scan_en),
    .raw_i       (in_i.data.raw_levels),
    .threshold_i (thr_q),
    .stable_d_o  (stable_d),
    .stable_q_o  (stable_q)
  );

  // pin levels a scan would drive now, from current modes and phases
  always_comb begin
    for (int i = 0; i < OUTPUT_CHANNELS; i++) begin
      case (mode_q[i])
        MODE_OFF:  pin_scan[i] = 1'b0;
        MODE_ON:   pin_scan[i] = 1'b1;
        MODE_SLOW: pin_scan[i] = slow_q;
        MODE_FAST: pin_scan[i] = fast_q;
        default:   pin_scan[i] = 1'b0;
      endcase
    end
  end

  assign tick_inc = {1'b0, tick_q} + (SLOW_BITS + 1)'(1);

  always_comb begin
    rise_d = rise_q;
    fall_d = fall_q;
    pin_d  = pin_q;
    fast_d = fast_q;
    slow_d = slow_q;
    tick_d = tick_q;
    seen   = 1'b0;
    for (int i = 0; i < OUTPUT_CHANNELS; i++) begin
      mode_d[i] = mode_q[i];
    end
    if (accept) begin
      case (in_i.data.command)
        CMD_SCAN: begin
          rise_d = rise_q | (stable_d & ~stable_q);
          fall_d = fall_q | (~stable_d & stable_q);
          pin_d  = pin_scan;
        end
        CMD_TICK: begin
          fast_d = ~fast_q;
          if (tick_inc > {1'b0, slow_ticks_q}) begin
            tick_d = '0;
            slow_d = ~slow_q;
          end else begin
            tick_d = tick_inc[SLOW_BITS-1:0];
          end
        end
        CMD_READ_RISE: begin
          for (int i = 0; i < INPUT_CHANNELS; i++) begin
            if (in_i.data.channel_index == CH_BITS'(i)) begin
              seen      = rise_q[i];
              rise_d[i] = 1'b0;
            end
          end
        end
        CMD_READ_FALL: begin
          for (int i = 0; i < INPUT_CHANNELS; i++) begin
            if (in_i.data.channel_index == CH_BITS'(i)) begin
              seen      = fall_q[i];
              fall_d[i] = 1'b0;
            end
          end
        end
        CMD_SET_MODE: begin
          for (int i = 0; i < OUTPUT_CHANNELS; i++) begin
            if (in_i.data.channel_index == CH_BITS'(i)) begin
              mode_d[i] = mode_e'(in_i.data.output_mode);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_q <= '0;
      fall_q <= '0;
      pin_q  <= '0;
      fast_q <= 1'b1;
      slow_q <= 1'b1;
      tick_q <= '0;
      for (int i = 0; i < OUTPUT_CHANNELS; i++) begin
        mode_q[i] <= MODE_OFF;
      end
    end else begin
      rise_q <= rise_d;
      fall_q <= fall_d;
      pin_q  <= pin_d;
      fast_q <= fast_d;
      slow_q <= slow_d;
      tick_q <= tick_d;
      for (int i = 0; i < OUTPUT_CHANNELS; i++) begin
        mode_q[i] <= mode_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q        <= THRESH_RESET;
      slow_ticks_q <= SLOW_TICKS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_THRESHOLD:  thr_q        <= cfg_data_i[THRESH_BITS-1:0];
        CFG_SLOW_TICKS: slow_ticks_q <= cfg_data_i[SLOW_BITS-1:0];
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q.stable_levels <= stable_d;
      out_data_q.pin_levels    <= pin_d;
      out_data_q.event_seen    <= seen;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

FILE: rtl/idebl_checker.sv
// Port-level checks for input_debounce_event_blink, attached by bind.
// Depends on idebl_pkg and the top level's ports.
module idebl_checker import idebl_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic [CMD_BITS-1:0] command_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic                event_seen_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // every accepted item shows a result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_i)
    else $error("no result after accepted item");

  // only read commands may report an event
  a_event_only_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (command_i != CMD_READ_RISE) && (command_i != CMD_READ_FALL)
      |=> !event_seen_i)
    else $error("event_seen set for non-read command");

  // a stalled result blocks new items
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("item taken while result stalled");

  // without a stall the block is always ready
  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i || out_ready_i |-> in_ready_i)
    else $error("input not ready while output free");

endmodule

bind input_debounce_event_blink idebl_checker u_idebl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .command_i    (in_i.data.command),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .event_seen_i (out_o.data.event_seen)
);
